// ===== rtl/mlpd_pkg.sv =====
`timescale 1ns / 1ps

package mlpd_pkg;

    localparam int NST = 17;
    localparam int NCH = 3;
    localparam int DIV_STAGES = 6;

    localparam logic [2:0] CFG_DYE_RED      = 3'd0;
    localparam logic [2:0] CFG_DYE_GREEN    = 3'd1;
    localparam logic [2:0] CFG_DYE_BLUE     = 3'd2;
    localparam logic [2:0] CFG_DYE_STRENGTH = 3'd3;
    localparam logic [2:0] CFG_LUMA_KEEP    = 3'd4;

    localparam logic [15:0] LUMA_R    = 16'd19595;
    localparam logic [15:0] LUMA_G    = 16'd38470;
    localparam logic [15:0] LUMA_B    = 16'd7471;
    localparam logic [23:0] FULL_Q16  = 24'd16711680;
    localparam logic [24:0] LIM_K     = 25'd16711681;
    localparam logic [15:0] MIX_DEN   = 16'd65280;
    localparam logic [31:0] RECIP_255 = 32'h80808081;
    localparam logic [8:0]  WT_ONE    = 9'd256;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [23:0] rem;
        logic [3:0]  q;
    } t_div_step;

    function automatic t_div_step div_step4(input logic [23:0] rem, input logic [3:0] bits,
                                            input logic [23:0] d);
        t_div_step   res;
        logic [24:0] t;
        logic [23:0] r;
        r = rem;
        res.q = 4'd0;
        for (int i = 3; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
                res.q[i] = 1'b1;
            end
            r = t[23:0];
        end
        res.rem = r;
        return res;
    endfunction

    function automatic logic [8:0] sat256(input logic [8:0] v);
        return (v > WT_ONE) ? WT_ONE : v;
    endfunction

endpackage

// ===== rtl/masked_luma_preserving_dye_unit.sv =====
`timescale 1ns / 1ps

// Masked luma-preserving dye: recolors one RGBA8 pixel per transaction.
// Input channel: i_valid / o_stall with red, green, blue, alpha and mask weight.
// Output channel: o_valid / i_stall with red, green, blue and alpha.
// Configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_idx
// (dye red, green, blue, strength, luma keep); write only while the pipe is empty.
// Between the edge that accepts an input and its result on the outputs lie
// 17 register stages.
// Throughput is one pixel per cycle while the receiver does not stall; the
// 17-stage pipe is bounded by the 32x32 reciprocal multiplies and a 24-bit
// quotient divider spread over six stages, four bits each.
// A mask of zero passes the pixel through; alpha always passes through.
// Reset clears all valid bits and loads the dye registers with white,
// full strength and full luma keep.
// When the receiver stalls with a result waiting, the whole pipe holds and
// o_stall rises in the same cycle; nothing is lost or repeated.

module masked_luma_preserving_dye_unit import mlpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_red_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_blue_in,
    input  logic [7:0] i_alpha_in,
    input  logic [7:0] i_mask_weight,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out,
    output logic [7:0] o_alpha_out,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [8:0] i_cfg_data
);

    t_byte       r_dye [NCH];
    logic [8:0]  r_strength;
    logic [8:0]  r_keep;

    logic        r_vld  [NST];
    t_byte       r_c    [NST][NCH];
    t_byte       r_a    [NST];
    t_byte       r_m    [NST];
    logic [16:0] r_w    [NST];
    logic [8:0]  r_kp   [NST];
    logic [23:0] r_base [NST];
    logic [23:0] r_dl   [3:NST-1];
    logic        r_zero [5:NST-1];
    logic [23:0] r_dyed [1:NST-1][NCH];
    logic        r_clip [5:NST-1][NCH];

    logic [16:0] r_x    [NCH];
    logic [39:0] r_lp   [NCH];
    logic [47:0] r_num  [NCH];
    logic [48:0] r_lim;
    logic [47:0] r_nd   [NCH];
    logic [23:0] r_drem [DIV_STAGES][NCH];
    logic [23:0] r_dn   [DIV_STAGES][NCH];
    logic [23:0] r_dq   [DIV_STAGES][NCH];
    logic [33:0] r_bsum [NCH];
    logic [23:0] r_blend[NCH];
    logic [40:0] r_ms   [NCH];
    logic [63:0] r_mp   [NCH];
    t_byte       r_out  [NCH];

    logic        en;
    t_byte       cin [NCH];

    logic [16:0] n_x    [NCH];
    logic [23:0] n_base;
    logic [63:0] prod_d [NCH];
    logic [23:0] n_dyed [NCH];
    logic [39:0] n_lp   [NCH];
    logic [40:0] lsum;
    logic [23:0] n_dl;
    logic [47:0] n_num  [NCH];
    logic [48:0] n_lim;
    logic [48:0] num2   [NCH];
    logic        n_clip [NCH];
    logic [47:0] n_nd   [NCH];
    t_div_step   dstep  [DIV_STAGES][NCH];
    logic [23:0] adj    [NCH];
    logic [33:0] n_bsum [NCH];
    logic [33:0] bround [NCH];
    logic [40:0] n_ms   [NCH];
    logic [63:0] n_mp   [NCH];
    logic [24:0] mixed  [NCH];
    logic [25:0] oround [NCH];
    t_byte       n_out  [NCH];

    assign en      = !(r_vld[NST-1] && i_stall);
    assign o_stall = !en;
    assign cin[0]  = i_red_in;
    assign cin[1]  = i_green_in;
    assign cin[2]  = i_blue_in;

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            n_x[ch] = 17'({9'd0, cin[ch]} * ({1'b0, r_dye[ch]} + 9'd255));
        end
        n_base = 24'({8'd0, LUMA_R} * {16'd0, i_red_in})
               + 24'({8'd0, LUMA_G} * {16'd0, i_green_in})
               + 24'({8'd0, LUMA_B} * {16'd0, i_blue_in});
        for (int ch = 0; ch < NCH; ch++) begin
            prod_d[ch] = 64'({15'd0, r_x[ch]} << 15 | 32'd127) * 64'(RECIP_255);
            n_dyed[ch] = prod_d[ch][62:39];
        end
        n_lp[0] = 40'({16'd0, r_dyed[1][0]} * {24'd0, LUMA_R});
        n_lp[1] = 40'({16'd0, r_dyed[1][1]} * {24'd0, LUMA_G});
        n_lp[2] = 40'({16'd0, r_dyed[1][2]} * {24'd0, LUMA_B});
        lsum = {1'b0, r_lp[0]} + {1'b0, r_lp[1]} + {1'b0, r_lp[2]} + 41'd32768;
        n_dl = lsum[39:16];
        for (int ch = 0; ch < NCH; ch++) begin
            n_num[ch] = {24'd0, r_dyed[3][ch]} * {24'd0, r_base[3]};
        end
        n_lim = {24'd0, LIM_K} * {25'd0, r_dl[3]};
        for (int ch = 0; ch < NCH; ch++) begin
            num2[ch]   = {1'b0, r_num[ch]} + {26'd0, r_dl[4][23:1]};
            n_clip[ch] = num2[ch] >= r_lim;
            n_nd[ch]   = (n_clip[ch] || r_dl[4] == 24'd0) ? 48'd0 : num2[ch][47:0];
        end
        for (int ch = 0; ch < NCH; ch++) begin
            dstep[0][ch] = div_step4(r_nd[ch][47:24], r_nd[ch][23:20], r_dl[5]);
            for (int k = 1; k < DIV_STAGES; k++) begin
                dstep[k][ch] = div_step4(r_drem[k-1][ch], r_dn[k-1][ch][23:20],
                                         r_dl[5+k]);
            end
        end
        for (int ch = 0; ch < NCH; ch++) begin
            adj[ch] = r_zero[11] ? 24'd0 : (r_clip[11][ch] ? FULL_Q16 : r_dq[DIV_STAGES-1][ch]);
            n_bsum[ch] = 34'({9'd0, r_dyed[11][ch]} * {24'd0, WT_ONE - r_kp[11]})
                       + 34'({9'd0, adj[ch]} * {24'd0, r_kp[11]});
            bround[ch] = r_bsum[ch] + 34'd128;
            n_ms[ch] = ({17'd0, r_c[13][ch], 16'd0} * {25'd0, MIX_DEN - 16'(r_w[13])})
                     + 41'({16'd0, r_blend[ch]} * {24'd0, r_w[13]})
                     + 41'd32640;
            n_mp[ch] = {32'd0, r_ms[ch][39:8]} * 64'(RECIP_255);
            mixed[ch] = r_mp[ch][63:39];
            oround[ch] = {1'b0, mixed[ch]} + 26'd32768;
            if (r_m[15] == 8'd0) begin
                n_out[ch] = r_c[15][ch];
            end else if (oround[ch][25:16] > 10'd255) begin
                n_out[ch] = 8'd255;
            end else begin
                n_out[ch] = oround[ch][23:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < NCH; ch++) begin
                r_dye[ch] <= 8'd255;
            end
            r_strength <= WT_ONE;
            r_keep     <= WT_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DYE_RED:      r_dye[0]   <= i_cfg_data[7:0];
                CFG_DYE_GREEN:    r_dye[1]   <= i_cfg_data[7:0];
                CFG_DYE_BLUE:     r_dye[2]   <= i_cfg_data[7:0];
                CFG_DYE_STRENGTH: r_strength <= i_cfg_data;
                CFG_LUMA_KEEP:    r_keep     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < NST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int ch = 0; ch < NCH; ch++) begin
                r_c[0][ch] <= cin[ch];
            end
            r_a[0]    <= i_alpha_in;
            r_m[0]    <= i_mask_weight;
            r_w[0]    <= 17'({8'd0, sat256(r_strength)} * {9'd0, i_mask_weight});
            r_kp[0]   <= sat256(r_keep);
            r_base[0] <= n_base;
            for (int s = 1; s < NST; s++) begin
                r_c[s]    <= r_c[s-1];
                r_a[s]    <= r_a[s-1];
                r_m[s]    <= r_m[s-1];
                r_w[s]    <= r_w[s-1];
                r_kp[s]   <= r_kp[s-1];
                r_base[s] <= r_base[s-1];
            end
            for (int s = 2; s < NST; s++) begin
                r_dyed[s] <= r_dyed[s-1];
            end
            for (int s = 4; s < NST; s++) begin
                r_dl[s] <= r_dl[s-1];
            end
            for (int s = 6; s < NST; s++) begin
                r_zero[s] <= r_zero[s-1];
                r_clip[s] <= r_clip[s-1];
            end
            r_dl[3]   <= n_dl;
            r_zero[5] <= (r_dl[4] == 24'd0);
            for (int ch = 0; ch < NCH; ch++) begin
                r_dyed[1][ch] <= n_dyed[ch];
                r_clip[5][ch] <= n_clip[ch];
                r_x[ch]       <= n_x[ch];
                r_lp[ch]      <= n_lp[ch];
                r_num[ch]     <= n_num[ch];
                r_nd[ch]      <= n_nd[ch];
                r_drem[0][ch] <= dstep[0][ch].rem;
                r_dn[0][ch]   <= {r_nd[ch][19:0], 4'd0};
                r_dq[0][ch]   <= {20'd0, dstep[0][ch].q};
                for (int k = 1; k < DIV_STAGES; k++) begin
                    r_drem[k][ch] <= dstep[k][ch].rem;
                    r_dn[k][ch]   <= {r_dn[k-1][ch][19:0], 4'd0};
                    r_dq[k][ch]   <= {r_dq[k-1][ch][19:0], dstep[k][ch].q};
                end
                r_bsum[ch]  <= n_bsum[ch];
                r_blend[ch] <= bround[ch][31:8];
                r_ms[ch]    <= n_ms[ch];
                r_mp[ch]    <= n_mp[ch];
                r_out[ch]   <= n_out[ch];
            end
            r_lim <= n_lim;
        end
    end

    assign o_valid     = r_vld[NST-1];
    assign o_red_out   = r_out[0];
    assign o_green_out = r_out[1];
    assign o_blue_out  = r_out[2];
    assign o_alpha_out = r_a[NST-1];

endmodule
